// ----- hdl/rfp_pkg.sv -----
`timescale 1ns / 1ps

package rfp_pkg;

  // Beat field widths
  localparam int MODE_W     = 3;
  localparam int POS_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int PIECE_W    = 12;
  localparam int NPIECES_W  = 13;
  localparam int RARITY_W   = 16;

  // Bitfield layout: bit TOP_BIT of a byte is the lowest piece
  localparam int BITS_PER_BYTE = 8;
  localparam int TOP_BIT       = 7;
  localparam int LANE_W        = 3;

  localparam logic [RARITY_W-1:0] RARITY_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_HAVE    = 3'd2,
    MODE_PICK    = 3'd3,
    MODE_RELEASE = 3'd4
  } mode_t;

endpackage

// ----- hdl/rfp_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rarest_first_piece_picker_unit.sv -----
`timescale 1ns / 1ps

// Rarest-first piece picker. Availability counters and in-flight bits live in
// two RAMs organized one row per bitfield byte (eight pieces per row), so each
// beat is one read-modify-write of a single row. An input beat is accepted in
// IDLE and updates its row in EXEC; the final byte of a pick run then passes
// FINISH, which waits for the result register and loads the result, and, when
// a piece is chosen, MARK, the read-modify-write that marks it in flight.
// After reset a clearing pass writes zeros to every row, during which in_ready
// is low; cfg writes are taken at any time. A pending result does not block
// new beats; only the next final pick byte waits for out_ready.
module rarest_first_piece_picker_unit #(
  parameter int MAX_PIECES = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [rfp_pkg::NPIECES_W-1:0]   cfg_num_pieces,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rfp_pkg::MODE_W-1:0]      in_mode,
  input  logic [rfp_pkg::POS_W-1:0]       in_byte_position,
  input  logic [rfp_pkg::BYTE_W-1:0]      in_peer_byte,
  input  logic [rfp_pkg::BYTE_W-1:0]      in_own_byte,
  input  logic [rfp_pkg::PIECE_W-1:0]     in_piece_index,
  input  logic                            in_last_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [rfp_pkg::PIECE_W-1:0]     out_chosen_piece,
  output logic [rfp_pkg::RARITY_W-1:0]    out_chosen_rarity
);

  localparam int LANES   = rfp_pkg::BITS_PER_BYTE;
  localparam int ROWS    = (MAX_PIECES + LANES - 1) / LANES;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AVAIL_W = LANES * COUNT_BITS;
  localparam int PW      = rfp_pkg::PIECE_W;
  localparam int POS_W   = rfp_pkg::POS_W;
  localparam int LANE_W  = rfp_pkg::LANE_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FINISH,
    ST_MARK
  } state_t;

  // registers
  state_t                        state_r, state_nxt;
  logic [ROW_AW-1:0]             clr_row_r, clr_row_nxt;
  logic [rfp_pkg::NPIECES_W-1:0] num_pieces_r, num_pieces_nxt;
  rfp_pkg::mode_t                mode_r, mode_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;     // byte row of the beat
  logic [LANE_W-1:0]             lane_r, lane_nxt;   // lane for have/release
  logic [rfp_pkg::BYTE_W-1:0]    peer_r, peer_nxt;
  logic [rfp_pkg::BYTE_W-1:0]    own_r, own_nxt;
  logic                          last_r, last_nxt;
  logic                          best_valid_r, best_valid_nxt;
  logic [COUNT_BITS-1:0]         best_count_r, best_count_nxt;
  logic [PW-1:0]                 best_piece_r, best_piece_nxt;
  logic [PW-1:0]                 mark_piece_r, mark_piece_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [PW-1:0]                 out_piece_r, out_piece_nxt;
  logic [rfp_pkg::RARITY_W-1:0]  out_rarity_r, out_rarity_nxt;

  // RAM ports
  logic                 avail_we, avail_re, flight_we, flight_re;
  logic [ROW_AW-1:0]    avail_waddr, avail_raddr, flight_waddr, flight_raddr;
  logic [AVAIL_W-1:0]   avail_wdata, avail_q;
  logic [LANES-1:0]     flight_wdata, flight_q;

  rfp_ram #(.WIDTH(AVAIL_W), .DEPTH(ROWS), .AW(ROW_AW)) u_avail_ram (
    .clk   (clk),
    .we    (avail_we),
    .waddr (avail_waddr),
    .wdata (avail_wdata),
    .re    (avail_re),
    .raddr (avail_raddr),
    .rdata (avail_q)
  );

  rfp_ram #(.WIDTH(LANES), .DEPTH(ROWS), .AW(ROW_AW)) u_flight_ram (
    .clk   (clk),
    .we    (flight_we),
    .waddr (flight_waddr),
    .wdata (flight_wdata),
    .re    (flight_re),
    .raddr (flight_raddr),
    .rdata (flight_q)
  );

  // have/release address the row of piece_index, the others byte_position
  logic [POS_W-1:0] in_row;
  logic             in_by_index;

  assign in_by_index = (in_mode == rfp_pkg::MODE_HAVE) || (in_mode == rfp_pkg::MODE_RELEASE);
  assign in_row = in_by_index ? in_piece_index[PW-1:LANE_W] : in_byte_position;

  assign in_ready = (state_r == ST_IDLE);

  // row and piece range checks of the beat in EXEC
  logic             row_ok;
  logic [PW-1:0]    idx_piece;
  logic             idx_in_lim, idx_in_mem;
  logic [LANES-1:0] lane_ok;

  assign row_ok     = 32'(pos_r) < ROWS;
  assign idx_piece  = {pos_r, lane_r};
  assign idx_in_mem = 32'(idx_piece) < MAX_PIECES;
  assign idx_in_lim = idx_in_mem && ({1'b0, idx_piece} < num_pieces_r);

  always_comb begin
    logic [PW-1:0] p;
    for (int j = 0; j < LANES; j++) begin
      p = {pos_r, LANE_W'(j)};
      lane_ok[j] = (32'(p) < MAX_PIECES) && ({1'b0, p} < num_pieces_r);
    end
  end

  // add / remove / have row update; lane j holds piece 8*pos + j
  logic [AVAIL_W-1:0] avail_mod;

  always_comb begin
    logic [COUNT_BITS-1:0] c;
    avail_mod = avail_q;
    for (int j = 0; j < LANES; j++) begin
      c = avail_q[j*COUNT_BITS +: COUNT_BITS];
      if (mode_r == rfp_pkg::MODE_HAVE) begin
        if (idx_in_lim && (lane_r == LANE_W'(j)) && (c != '1)) begin
          c = c + COUNT_BITS'(1);
        end
      end else if (lane_ok[j] && peer_r[rfp_pkg::TOP_BIT - j]) begin
        if (mode_r == rfp_pkg::MODE_ADD) begin
          if (c != '1) c = c + COUNT_BITS'(1);
        end else begin
          if (c != '0) c = c - COUNT_BITS'(1);
        end
      end
      avail_mod[j*COUNT_BITS +: COUNT_BITS] = c;
    end
  end

  // pick: fold the byte into the running best. The lanes reduce as a balanced
  // tree keyed on (count, piece), so ties still go to the lower index.
  logic                  pk_valid;
  logic [COUNT_BITS-1:0] pk_count;
  logic [PW-1:0]         pk_piece;

  // true when candidate b beats candidate a
  function automatic logic takes_over(input logic va, input logic [COUNT_BITS-1:0] ca,
                                      input logic [PW-1:0] pa, input logic vb,
                                      input logic [COUNT_BITS-1:0] cb,
                                      input logic [PW-1:0] pb);
    return vb && (!va || (cb < ca) || ((cb == ca) && (pb < pa)));
  endfunction

  always_comb begin
    // heap layout: leaves at LANES..2*LANES-1, node n merges 2n and 2n+1
    logic                  tv [2*LANES];
    logic [COUNT_BITS-1:0] tc [2*LANES];
    logic [PW-1:0]         tp [2*LANES];
    tv[0] = 1'b0;
    tc[0] = '0;
    tp[0] = '0;
    for (int j = 0; j < LANES; j++) begin
      tv[LANES+j] = lane_ok[j] && peer_r[rfp_pkg::TOP_BIT - j]
                    && !own_r[rfp_pkg::TOP_BIT - j] && !flight_q[j];
      tc[LANES+j] = avail_q[j*COUNT_BITS +: COUNT_BITS];
      tp[LANES+j] = {pos_r, LANE_W'(j)};
    end
    for (int n = LANES - 1; n >= 1; n--) begin
      if (takes_over(tv[2*n], tc[2*n], tp[2*n], tv[2*n+1], tc[2*n+1], tp[2*n+1])) begin
        tv[n] = tv[2*n+1];
        tc[n] = tc[2*n+1];
        tp[n] = tp[2*n+1];
      end else begin
        tv[n] = tv[2*n];
        tc[n] = tc[2*n];
        tp[n] = tp[2*n];
      end
    end
    if (takes_over(best_valid_r, best_count_r, best_piece_r, tv[1], tc[1], tp[1])) begin
      pk_valid = 1'b1;
      pk_count = tc[1];
      pk_piece = tp[1];
    end else begin
      pk_valid = best_valid_r;
      pk_count = best_count_r;
      pk_piece = best_piece_r;
    end
  end

  // rarity clamps to the 16-bit field for wide counters
  logic [COUNT_BITS+rfp_pkg::RARITY_W-1:0] best_ext;
  logic [rfp_pkg::RARITY_W-1:0]            best_rarity;

  assign best_ext    = (COUNT_BITS + rfp_pkg::RARITY_W)'(best_count_r);
  assign best_rarity = (best_ext > (COUNT_BITS + rfp_pkg::RARITY_W)'(rfp_pkg::RARITY_MAX))
                       ? rfp_pkg::RARITY_MAX : best_ext[rfp_pkg::RARITY_W-1:0];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    clr_row_nxt    = clr_row_r;
    num_pieces_nxt = cfg_we ? cfg_num_pieces : num_pieces_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    lane_nxt       = lane_r;
    peer_nxt       = peer_r;
    own_nxt        = own_r;
    last_nxt       = last_r;
    best_valid_nxt = best_valid_r;
    best_count_nxt = best_count_r;
    best_piece_nxt = best_piece_r;
    mark_piece_nxt = mark_piece_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_piece_nxt  = out_piece_r;
    out_rarity_nxt = out_rarity_r;

    avail_we     = 1'b0;
    avail_waddr  = ROW_AW'(pos_r);
    avail_wdata  = avail_mod;
    avail_re     = 1'b0;
    avail_raddr  = ROW_AW'(in_row);
    flight_we    = 1'b0;
    flight_waddr = ROW_AW'(pos_r);
    flight_wdata = flight_q;
    flight_re    = 1'b0;
    flight_raddr = ROW_AW'(in_row);

    case (state_r)
      ST_CLEAR: begin
        avail_we     = 1'b1;
        avail_waddr  = clr_row_r;
        avail_wdata  = '0;
        flight_we    = 1'b1;
        flight_waddr = clr_row_r;
        flight_wdata = '0;
        clr_row_nxt  = clr_row_r + ROW_AW'(1);
        if (clr_row_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          avail_re  = 1'b1;
          flight_re = 1'b1;
          mode_nxt  = rfp_pkg::mode_t'(in_mode);
          pos_nxt   = in_row;
          lane_nxt  = in_piece_index[LANE_W-1:0];
          peer_nxt  = in_peer_byte;
          own_nxt   = in_own_byte;
          last_nxt  = in_last_byte;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (mode_r)
          rfp_pkg::MODE_ADD, rfp_pkg::MODE_REMOVE, rfp_pkg::MODE_HAVE: begin
            avail_we = row_ok;
          end
          rfp_pkg::MODE_PICK: begin
            best_valid_nxt = pk_valid;
            best_count_nxt = pk_count;
            best_piece_nxt = pk_piece;
            if (last_r) state_nxt = ST_FINISH;
          end
          rfp_pkg::MODE_RELEASE: begin
            flight_we    = idx_in_mem;
            flight_wdata = flight_q & ~(LANES'(1) << lane_r);
          end
          default: begin
          end
        endcase
      end
      ST_FINISH: begin
        // wait for the result register, then report and reset the run
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = best_valid_r;
          out_piece_nxt  = best_valid_r ? best_piece_r : '0;
          out_rarity_nxt = best_valid_r ? best_rarity : '0;
          mark_piece_nxt = best_piece_r;
          best_valid_nxt = 1'b0;
          best_count_nxt = '1;
          best_piece_nxt = '0;
          flight_re      = best_valid_r;
          flight_raddr   = ROW_AW'(best_piece_r[PW-1:LANE_W]);
          state_nxt      = best_valid_r ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        flight_we    = 1'b1;
        flight_waddr = ROW_AW'(mark_piece_r[PW-1:LANE_W]);
        flight_wdata = flight_q | (LANES'(1) << mark_piece_r[LANE_W-1:0]);
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_row_r    <= '0;
      num_pieces_r <= '0;
      best_valid_r <= 1'b0;
      best_count_r <= '1;
      best_piece_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_row_r    <= clr_row_nxt;
      num_pieces_r <= num_pieces_nxt;
      best_valid_r <= best_valid_nxt;
      best_count_r <= best_count_nxt;
      best_piece_r <= best_piece_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    pos_r        <= pos_nxt;
    lane_r       <= lane_nxt;
    peer_r       <= peer_nxt;
    own_r        <= own_nxt;
    last_r       <= last_nxt;
    mark_piece_r <= mark_piece_nxt;
    out_found_r  <= out_found_nxt;
    out_piece_r  <= out_piece_nxt;
    out_rarity_r <= out_rarity_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_chosen_piece  = out_piece_r;
  assign out_chosen_rarity = out_rarity_r;

  // a not-found beat carries zero fields
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_piece_r == '0) && (out_rarity_r == '0))
    else $error("not-found result with nonzero fields");

  // a new result always starts a fresh run
  a_run_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> !best_valid_r)
    else $error("running best not cleared after report");

  // the in-flight mark follows a found result loaded in the previous cycle
  a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (out_valid_r && out_found_r && (out_piece_r == mark_piece_r)))
    else $error("in-flight mark without a found result");

  // a chosen piece is always in range
  a_piece_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> ({1'b0, out_piece_r} < num_pieces_r))
    else $error("chosen piece beyond piece count");

endmodule

// ----- dv/rarest_first_piece_picker_unit_test.sv -----
`timescale 1ns / 1ps

module rarest_first_piece_picker_unit_test;

  localparam int PIECES      = 4096;
  localparam int CYCLE_LIMIT = 100_000;
  // Slack for a final pick byte that marks a piece to finish its MARK update
  localparam int SETTLE_CYCLES = 8;
  // Adds piled onto one counter
  localparam int PILE_BEATS = 24;

  // Modes that the block must ignore
  localparam logic [rfp_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [rfp_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic                         found;
    logic [rfp_pkg::PIECE_W-1:0]  piece;
    logic [rfp_pkg::RARITY_W-1:0] rarity;
  } pick_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rfp_pkg::NPIECES_W-1:0] cfg_num_pieces = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [rfp_pkg::MODE_W-1:0]    in_mode = '0;
  logic [rfp_pkg::POS_W-1:0]     in_byte_position = '0;
  logic [rfp_pkg::BYTE_W-1:0]    in_peer_byte = '0;
  logic [rfp_pkg::BYTE_W-1:0]    in_own_byte = '0;
  logic [rfp_pkg::PIECE_W-1:0]   in_piece_index = '0;
  logic                          in_last_byte = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_found;
  logic [rfp_pkg::PIECE_W-1:0]   out_chosen_piece;
  logic [rfp_pkg::RARITY_W-1:0]  out_chosen_rarity;

  rarest_first_piece_picker_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_num_pieces    (cfg_num_pieces),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_byte_position  (in_byte_position),
    .in_peer_byte      (in_peer_byte),
    .in_own_byte       (in_own_byte),
    .in_piece_index    (in_piece_index),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_chosen_piece  (out_chosen_piece),
    .out_chosen_rarity (out_chosen_rarity)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the picker state. Updated at the edge where a beat is taken,
  // so it always reflects the order in which the block sees the beats.
  // ---------------------------------------------------------------------------
  logic [rfp_pkg::RARITY_W-1:0] avail_cnt [PIECES];
  bit                           in_flight_map [PIECES];
  logic [rfp_pkg::RARITY_W-1:0] run_best_cnt = rfp_pkg::RARITY_MAX;
  int                           run_best_piece = 0;
  bit                           run_best_ok = 1'b0;
  int                           piece_lim = 0;      // min(num_pieces, PIECES)

  pick_result_t pending_picks[$];          // picks reported by last bytes, not yet seen

  // Bookkeeping shared by the processes
  int  errors = 0;
  int  beats_sent = 0;
  int  picks_checked = 0;
  int  picks_found = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;                     // random gaps and stalls on both channels
  int  out_stall = 0;
  int  focus_base = 0;                     // first byte of the window random traffic aims at

  initial begin
    foreach (avail_cnt[i]) avail_cnt[i] = '0;
  end

  // Rarest-first bookkeeping for one beat.
  task automatic apply_beat(input logic [rfp_pkg::MODE_W-1:0] mode,
                            input logic [rfp_pkg::POS_W-1:0] pos,
                            input logic [rfp_pkg::BYTE_W-1:0] peer,
                            input logic [rfp_pkg::BYTE_W-1:0] own,
                            input logic [rfp_pkg::PIECE_W-1:0] idx, input logic last);
    int base;
    int p;
    pick_result_t res;
    base = int'(pos) * rfp_pkg::BITS_PER_BYTE;
    case (mode)
      rfp_pkg::MODE_ADD, rfp_pkg::MODE_REMOVE: begin
        for (int k = 0; k < rfp_pkg::BITS_PER_BYTE; k++) begin
          p = base + k;
          if (p < piece_lim && peer[rfp_pkg::TOP_BIT-k]) begin
            if (mode == rfp_pkg::MODE_ADD) begin
              if (avail_cnt[p] != rfp_pkg::RARITY_MAX) avail_cnt[p]++;
            end else if (avail_cnt[p] != '0) begin
              avail_cnt[p]--;
            end
          end
        end
      end
      rfp_pkg::MODE_HAVE: begin
        if (int'(idx) < piece_lim && avail_cnt[idx] != rfp_pkg::RARITY_MAX) avail_cnt[idx]++;
      end
      rfp_pkg::MODE_PICK: begin
        for (int k = 0; k < rfp_pkg::BITS_PER_BYTE; k++) begin
          p = base + k;
          if (p < piece_lim && peer[rfp_pkg::TOP_BIT-k] && !own[rfp_pkg::TOP_BIT-k] &&
              !in_flight_map[p]) begin
            // lower count wins; equal count goes to the lower index
            if (!run_best_ok || avail_cnt[p] < run_best_cnt ||
                (avail_cnt[p] == run_best_cnt && p < run_best_piece)) begin
              run_best_ok    = 1'b1;
              run_best_cnt   = avail_cnt[p];
              run_best_piece = p;
            end
          end
        end
        if (last) begin
          res = '0;
          if (run_best_ok) begin
            res.found  = 1'b1;
            res.piece  = run_best_piece[rfp_pkg::PIECE_W-1:0];
            res.rarity = run_best_cnt;
            in_flight_map[run_best_piece] = 1'b1;
          end
          pending_picks = {pending_picks, res};
          run_best_ok    = 1'b0;
          run_best_cnt   = rfp_pkg::RARITY_MAX;
          run_best_piece = 0;
        end
      end
      rfp_pkg::MODE_RELEASE: in_flight_map[idx] = 1'b0;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side. A beat starts at a falling edge; the task returns at the rising
  // edge where it was taken, so a following beat can keep valid high without a
  // second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [rfp_pkg::MODE_W-1:0] mode,
                           input logic [rfp_pkg::POS_W-1:0] pos,
                           input logic [rfp_pkg::BYTE_W-1:0] peer,
                           input logic [rfp_pkg::BYTE_W-1:0] own,
                           input logic [rfp_pkg::PIECE_W-1:0] idx, input logic last);
    int gap;
    @(negedge clk);
    gap = idle_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_byte_position <= pos;
    in_peer_byte     <= peer;
    in_own_byte      <= own;
    in_piece_index   <= idx;
    in_last_byte     <= last;
    do @(posedge clk); while (!in_ready);
    apply_beat(mode, pos, peer, own, idx, last);
    beats_sent++;
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Hold the sender until every outstanding pick has been reported.
  task automatic hold_for_results();
    pause_input();
    while (pending_picks.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the block quiet.
  task automatic write_piece_count(input int value);
    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_num_pieces <= value[rfp_pkg::NPIECES_W-1:0];
    piece_lim = (value < PIECES) ? value : PIECES;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall drawn per result, compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    pick_result_t got;
    pick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_found, out_chosen_piece, out_chosen_rarity};
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0d piece=%0d rarity=%0d",
                 $time, got.found, got.piece, got.rarity);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        picks_checked++;
        if (want.found) picks_found++;
        if (got.found !== want.found)
          report_field("found", int'(want.found), int'(got.found));
        if (got.piece !== want.piece)
          report_field("chosen_piece", int'(want.piece), int'(got.piece));
        if (got.rarity !== want.rarity)
          report_field("chosen_rarity", int'(want.rarity), int'(got.rarity));
      end
      out_stall = idle_on ? $urandom_range(7, 0) : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d picks outstanding",
               $time, cycle_count, pending_picks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic logic [rfp_pkg::BYTE_W-1:0] rnd_byte();
    return rfp_pkg::BYTE_W'($urandom);
  endfunction

  function automatic logic [rfp_pkg::PIECE_W-1:0] rnd_index();
    return rfp_pkg::PIECE_W'($urandom);
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1, 0));
  endfunction

  // Byte position, mostly inside a small window of in-range pieces so that
  // counts pile up and picks compete; now and then anywhere.
  function automatic logic [rfp_pkg::POS_W-1:0] focus_pos();
    int top;
    top = (piece_lim == 0) ? 0 : (piece_lim - 1) / rfp_pkg::BITS_PER_BYTE;
    if ($urandom_range(9, 0) == 0) return rfp_pkg::POS_W'($urandom_range(511, 0));
    return rfp_pkg::POS_W'($urandom_range((focus_base + 3 < top) ? focus_base + 3 : top,
                                          focus_base));
  endfunction

  // Piece index, in range most of the time.
  function automatic logic [rfp_pkg::PIECE_W-1:0] focus_index();
    if (piece_lim > 0 && $urandom_range(3, 0) != 0)
      return rfp_pkg::PIECE_W'(int'(focus_pos()) * rfp_pkg::BITS_PER_BYTE +
                               $urandom_range(rfp_pkg::TOP_BIT, 0));
    return rnd_index();
  endfunction

  function automatic logic [rfp_pkg::MODE_W-1:0] MODE_FIRST_SPARE();
    return rfp_pkg::MODE_W'($urandom_range(int'(MODE_SPARE_LAST), int'(MODE_SPARE_FIRST)));
  endfunction

  // Anything that is not a pick byte, unused fields randomized.
  task automatic send_side_beat();
    int sel;
    sel = $urandom_range(19, 0);
    if (sel < 9)
      send_beat(rfp_pkg::MODE_ADD, focus_pos(), rnd_byte(), rnd_byte(), rnd_index(), rnd_bit());
    else if (sel < 12)
      send_beat(rfp_pkg::MODE_REMOVE, focus_pos(), rnd_byte(), rnd_byte(), rnd_index(),
                rnd_bit());
    else if (sel < 15)
      send_beat(rfp_pkg::MODE_HAVE, rfp_pkg::POS_W'($urandom), rnd_byte(), rnd_byte(),
                focus_index(), rnd_bit());
    else if (sel < 19)
      send_beat(rfp_pkg::MODE_RELEASE, rfp_pkg::POS_W'($urandom), rnd_byte(), rnd_byte(),
                focus_index(), rnd_bit());
    else
      send_beat(MODE_FIRST_SPARE(), rfp_pkg::POS_W'($urandom), rnd_byte(), rnd_byte(),
                rnd_index(), rnd_bit());
  endtask

  // One pick run of 1..4 bytes, other beats sometimes slipped in between.
  task automatic send_pick_run(output int n_beats);
    int len;
    len = $urandom_range(4, 1);
    n_beats = len;
    for (int b = 0; b < len; b++) begin
      // own byte kept sparse so the peer usually offers something
      send_beat(rfp_pkg::MODE_PICK, focus_pos(), rnd_byte(), rnd_byte() & rnd_byte(),
                rnd_index(), b == len - 1);
      if (b != len - 1 && $urandom_range(4, 0) == 0) begin
        send_side_beat();
        n_beats++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the piece count is zero: nothing counts, nothing is picked.
  task automatic test_empty_torrent();
    send_beat(rfp_pkg::MODE_ADD, 9'd0, 8'hFF, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'hFF, 8'h00, 12'd0, 1'b1);
    write_piece_count(0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'hFF, 8'h00, 12'd0, 1'b1);
  endtask

  // Add, remove and have on a 20-piece torrent, including the partial last
  // byte, a far byte that is out of range and removes that hit zero.
  task automatic test_counting();
    write_piece_count(20);
    send_beat(rfp_pkg::MODE_ADD, 9'd0, 8'hFF, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_ADD, 9'd1, 8'hA5, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_ADD, 9'd2, 8'hFF, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_ADD, 9'd511, 8'hFF, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_ADD, 9'd0, 8'h0F, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_REMOVE, 9'd0, 8'h80, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_REMOVE, 9'd1, 8'h5A, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd19, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd20, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd4095, 1'b0);
  endtask

  // Pick rules: byte order, repeats, ties, interleaved beats, nothing found,
  // release and re-pick, unused modes.
  task automatic test_pick_rules();
    send_beat(rfp_pkg::MODE_PICK, 9'd1, 8'hFF, 8'h40, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'hFF, 8'h00, 12'd0, 1'b1);
    send_beat(rfp_pkg::MODE_PICK, 9'd1, 8'hFF, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd1, 8'hFF, 8'h00, 12'd0, 1'b0);
    // counts change mid-run; the running best keeps what it saw
    send_beat(rfp_pkg::MODE_ADD, 9'd1, 8'h18, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd2, 8'hFF, 8'h00, 12'd0, 1'b1);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'h00, 8'h00, 12'd0, 1'b1);
    send_beat(rfp_pkg::MODE_PICK, 9'd2, 8'hF0, 8'hF0, 12'd0, 1'b1);
    send_beat(rfp_pkg::MODE_RELEASE, 9'd0, 8'h00, 8'h00, 12'd9, 1'b0);
    send_beat(rfp_pkg::MODE_RELEASE, 9'd0, 8'h00, 8'h00, 12'd4095, 1'b0);
    send_beat(MODE_SPARE_FIRST, 9'd0, 8'hFF, 8'h00, 12'd9, 1'b1);
    send_beat(MODE_SPARE_LAST, 9'd511, 8'hFF, 8'h00, 12'd4095, 1'b1);
    send_beat(rfp_pkg::MODE_PICK, 9'd1, 8'h40, 8'h00, 12'd0, 1'b1);
  endtask

  // Pile counts onto one piece back to back, check it still wins when it is
  // the only candidate, then back off.
  task automatic test_counter_load();
    write_piece_count(8);
    idle_on = 1'b0;
    repeat (PILE_BEATS) send_beat(rfp_pkg::MODE_ADD, 9'd0, 8'h01, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd7, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'h01, 8'h00, 12'd0, 1'b1);
    send_beat(rfp_pkg::MODE_REMOVE, 9'd0, 8'h01, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_RELEASE, 9'd0, 8'h00, 8'h00, 12'd7, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd0, 8'hFF, 8'hFE, 12'd0, 1'b1);
    idle_on = 1'b1;
  endtask

  // Largest piece counts: the register value past the array size clips, and
  // the very last piece can be chosen.
  task automatic test_edge_pieces();
    write_piece_count(8191);
    send_beat(rfp_pkg::MODE_ADD, 9'd511, 8'h01, 8'h00, 12'd0, 1'b0);
    send_beat(rfp_pkg::MODE_HAVE, 9'd0, 8'h00, 8'h00, 12'd4095, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd511, 8'h01, 8'h00, 12'd0, 1'b1);
    write_piece_count(PIECES);
    send_beat(rfp_pkg::MODE_RELEASE, 9'd0, 8'h00, 8'h00, 12'd4095, 1'b0);
    send_beat(rfp_pkg::MODE_PICK, 9'd511, 8'hFF, 8'hFE, 12'd0, 1'b1);
  endtask

  // Random traffic over several piece counts, mostly pick runs with counts
  // and releases churning around them.
  task automatic test_random_traffic();
    int counts[8];
    int done;
    int n;
    int top;
    counts = '{3, 8, 37, 64, 200, PIECES, 8191, 0};
    counts[7] = $urandom_range(PIECES, 1);
    foreach (counts[ph]) begin
      write_piece_count(counts[ph]);
      top = (piece_lim == 0) ? 0 : (piece_lim - 1) / rfp_pkg::BITS_PER_BYTE;
      focus_base = $urandom_range(top, 0);
      idle_on = (ph % 3) != 1;     // some phases run flat out
      done = 0;
      while (done < 45) begin
        if ($urandom_range(99, 0) < 55) begin
          send_pick_run(n);
          done += n;
        end else begin
          send_side_beat();
          done++;
        end
        if (done >= 25 && done < 30) hold_for_results();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_torrent();
    test_counting();
    test_pick_rules();
    test_counter_load();
    test_edge_pieces();
    test_random_traffic();

    pause_input();
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats over piece counts 0 to 8191, with one heavily loaded counter;",
             beats_sent);
    $display("checked %0d pick results, %0d of them with a piece chosen.",
             picks_checked, picks_found);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
